// File: rtl/ipv4p_pkg.sv
// Package with shared types and constants of the IPv4 line address parser.
`timescale 1ns / 1ps

package ipv4p_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_INVALID = 2'd1,
		ST_IGNORE  = 2'd2
	} status_t;

	// Parser phase: skipping leading whitespace, then reading field one to four.
	typedef enum logic [2:0] {
		PH_SKIP = 3'd0,
		PH_F1   = 3'd1,
		PH_F2   = 3'd2,
		PH_F3   = 3'd3,
		PH_F4   = 3'd4
	} phase_t;

	// Control state that travels between the top level and the byte step logic.
	typedef struct packed {
		phase_t  phase;
		status_t held_status;
		logic    decided;
	} ctl_t;

	localparam logic [7:0]  CH_NUL    = 8'h00;
	localparam logic [7:0]  CH_SPACE  = 8'h20;
	localparam logic [7:0]  CH_DOT    = 8'h2E;
	localparam logic [30:0] FIELD_MAX = 31'h7FFF_FFFF;

endpackage

// File: rtl/ipv4p_in_if.sv
// Channel interface that carries one text byte item of a line.
`timescale 1ns / 1ps

interface ipv4p_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_buffer;

	modport source (output valid, output text_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

// File: rtl/ipv4p_out_if.sv
// Channel interface that carries one parse result item.
`timescale 1ns / 1ps

interface ipv4p_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [1:0]  status;

	modport source (output valid, output address, output status, input ready);
	modport sink   (input valid, input address, input status, output ready);
endinterface

// File: rtl/ipv4p_byte_step.sv
// Next-state logic of the parser for one byte, including the line result.
`timescale 1ns / 1ps

module ipv4p_byte_step #(
	parameter int MAX_DIGITS = 32,
	localparam int DC_W = $clog2(MAX_DIGITS + 1)
) (
	input  logic [7:0]       text_byte,
	input  logic             end_of_buffer,
	input  ipv4p_pkg::ctl_t  ctl,
	input  logic [DC_W-1:0]  digit_count,
	input  logic [30:0]      field_value,
	input  logic [31:0]      assembled,
	output ipv4p_pkg::ctl_t  ctl_nxt,
	output logic [DC_W-1:0]  digit_count_nxt,
	output logic [30:0]      field_value_nxt,
	output logic [31:0]      assembled_nxt,
	output logic             emit,
	output logic [31:0]      res_address,
	output ipv4p_pkg::status_t res_status
);

	logic               is_space;
	logic               is_digit;
	logic               is_dot;
	logic               proceed;
	ipv4p_pkg::phase_t  ph;
	logic [34:0]        times_ten;
	logic [30:0]        sat_value;
	logic [31:0]        closed;
	ipv4p_pkg::ctl_t    c_nxt;
	logic [DC_W-1:0]    dc_nxt;
	logic [30:0]        fv_nxt;
	logic [31:0]        as_nxt;

	// Character classes.
	assign is_space = (text_byte == ipv4p_pkg::CH_SPACE) ||
			(text_byte inside {[8'd9:8'd13]});
	assign is_digit = text_byte inside {[8'h30:8'h39]};
	assign is_dot   = (text_byte == ipv4p_pkg::CH_DOT);

	// Field value times ten plus the new digit, saturated.
	assign times_ten = {1'b0, field_value, 3'b000} + {3'b000, field_value, 1'b0}
			+ {31'd0, text_byte[3:0]};
	assign sat_value = (times_ten > {4'd0, ipv4p_pkg::FIELD_MAX}) ?
			ipv4p_pkg::FIELD_MAX : times_ten[30:0];

	// The finished field moved to its place in the address.
	always_comb begin
		case (ph)
			ipv4p_pkg::PH_F1: closed = assembled | {field_value[7:0], 24'd0};
			ipv4p_pkg::PH_F2: closed = assembled | {field_value[15:0], 16'd0};
			ipv4p_pkg::PH_F3: closed = assembled | {field_value[23:0], 8'd0};
			ipv4p_pkg::PH_F4: closed = assembled | {1'b0, field_value};
			default:          closed = assembled;
		endcase
	end

	// Byte handling while the line is still undecided.
	always_comb begin
		c_nxt   = ctl;
		dc_nxt  = digit_count;
		fv_nxt  = field_value;
		as_nxt  = assembled;
		proceed = 1'b0;
		ph      = ctl.phase;
		if (!ctl.decided) begin
			proceed = 1'b1;
			if (ctl.phase == ipv4p_pkg::PH_SKIP) begin
				if (is_space) begin
					proceed = 1'b0;
					if (end_of_buffer) begin
						c_nxt.held_status = ipv4p_pkg::ST_IGNORE;
						c_nxt.decided     = 1'b1;
					end
				end else if (text_byte == ipv4p_pkg::CH_NUL) begin
					proceed           = 1'b0;
					c_nxt.held_status = ipv4p_pkg::ST_IGNORE;
					c_nxt.decided     = 1'b1;
				end else begin
					ph = ipv4p_pkg::PH_F1;
				end
			end
			c_nxt.phase = ph;
			if (proceed) begin
				case (ph)
					ipv4p_pkg::PH_F1, ipv4p_pkg::PH_F2, ipv4p_pkg::PH_F3,
					ipv4p_pkg::PH_F4: begin
						if (is_digit) begin
							if (digit_count >= DC_W'(MAX_DIGITS)) begin
								c_nxt.held_status = ipv4p_pkg::ST_INVALID;
								c_nxt.decided     = 1'b1;
							end else begin
								dc_nxt = digit_count + DC_W'(1);
								fv_nxt = sat_value;
								if (end_of_buffer) begin
									c_nxt.held_status = ipv4p_pkg::ST_INVALID;
									c_nxt.decided     = 1'b1;
								end
							end
						end else if (ph != ipv4p_pkg::PH_F4 && is_dot) begin
							if (digit_count == '0 || end_of_buffer) begin
								c_nxt.held_status = ipv4p_pkg::ST_INVALID;
								c_nxt.decided     = 1'b1;
							end else begin
								as_nxt = closed;
								dc_nxt = '0;
								fv_nxt = '0;
								case (ph)
									ipv4p_pkg::PH_F1: c_nxt.phase = ipv4p_pkg::PH_F2;
									ipv4p_pkg::PH_F2: c_nxt.phase = ipv4p_pkg::PH_F3;
									default:          c_nxt.phase = ipv4p_pkg::PH_F4;
								endcase
							end
						end else if (ph == ipv4p_pkg::PH_F4 &&
								(is_space || text_byte == ipv4p_pkg::CH_NUL)) begin
							c_nxt.decided = 1'b1;
							if (digit_count == '0) begin
								c_nxt.held_status = ipv4p_pkg::ST_INVALID;
							end else begin
								as_nxt            = closed;
								c_nxt.held_status = ipv4p_pkg::ST_VALID;
							end
						end else begin
							c_nxt.held_status = ipv4p_pkg::ST_INVALID;
							c_nxt.decided     = 1'b1;
						end
					end
					default: begin
						c_nxt.held_status = ipv4p_pkg::ST_INVALID;
						c_nxt.decided     = 1'b1;
					end
				endcase
			end
		end
	end

	// Result on the last byte of the buffer, then back to the reset state.
	always_comb begin
		emit            = end_of_buffer;
		res_status      = c_nxt.decided ? c_nxt.held_status : ipv4p_pkg::ST_INVALID;
		res_address     = (res_status == ipv4p_pkg::ST_VALID) ? as_nxt : 32'd0;
		ctl_nxt         = c_nxt;
		digit_count_nxt = dc_nxt;
		field_value_nxt = fv_nxt;
		assembled_nxt   = as_nxt;
		if (end_of_buffer) begin
			ctl_nxt.phase       = ipv4p_pkg::PH_SKIP;
			ctl_nxt.held_status = ipv4p_pkg::ST_VALID;
			ctl_nxt.decided     = 1'b0;
			digit_count_nxt     = '0;
			field_value_nxt     = '0;
			assembled_nxt       = '0;
		end
	end

endmodule

// File: rtl/ipv4_line_address_parser.sv
// Top level of the streaming IPv4 dotted-decimal line address parser.
// Usage:
//   The line channel takes one text byte item per cycle while no last byte
//   waits; end_of_buffer marks the last byte of a line. The result channel
//   gives exactly one item per line: the 32-bit address (zero unless status
//   is valid) and the status (valid, invalid or ignored blank line).
//   A byte item is taken into an input register, parsed by short logic that
//   updates the line state, and the line result lands in an output register.
//   Throughput is one byte item per cycle while no last byte waits for the
//   output register; the field value is updated by a single multiply-by-ten
//   and saturation compare.
//   When the receiver stalls, the result stays in the output register; bytes
//   that produce no result keep flowing, and only a last byte waits in the
//   input register until the output register frees up.
//   Reset clears both registers' valid flags and returns the parser to the
//   start of a line.
`timescale 1ns / 1ps

module ipv4_line_address_parser #(
	parameter int MAX_DIGITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	ipv4p_in_if.sink            line,
	ipv4p_out_if.source         result
);

	localparam int DC_W = $clog2(MAX_DIGITS + 1);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eob_s1;
	logic                adv_s1;
	logic                out_free;

	ipv4p_pkg::ctl_t     ctl_q;
	logic [DC_W-1:0]     digit_count_q;
	logic [30:0]         field_value_q;
	logic [31:0]         assembled_q;

	ipv4p_pkg::ctl_t     ctl_nxt;
	logic [DC_W-1:0]     digit_count_nxt;
	logic [30:0]         field_value_nxt;
	logic [31:0]         assembled_nxt;
	logic                emit;
	logic [31:0]         res_address;
	ipv4p_pkg::status_t  res_status;

	logic                out_valid_q;
	logic [31:0]         address_q;
	ipv4p_pkg::status_t  status_q;

	// Handshake: the input register moves on unless it holds a last byte
	// while the output register is still occupied.
	assign out_free   = !out_valid_q || result.ready;
	assign adv_s1     = valid_s1 && (!eob_s1 || out_free);
	assign line.ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line.ready) begin
			valid_s1 <= line.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line.ready && line.valid) begin
			byte_s1 <= line.text_byte;
			eob_s1  <= line.end_of_buffer;
		end
	end

	// Per-byte parse logic.
	ipv4p_byte_step #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_step (
		.text_byte       (byte_s1),
		.end_of_buffer   (eob_s1),
		.ctl             (ctl_q),
		.digit_count     (digit_count_q),
		.field_value     (field_value_q),
		.assembled       (assembled_q),
		.ctl_nxt         (ctl_nxt),
		.digit_count_nxt (digit_count_nxt),
		.field_value_nxt (field_value_nxt),
		.assembled_nxt   (assembled_nxt),
		.emit            (emit),
		.res_address     (res_address),
		.res_status      (res_status)
	);

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q         <= '{phase: ipv4p_pkg::PH_SKIP,
					held_status: ipv4p_pkg::ST_VALID, decided: 1'b0};
			digit_count_q <= '0;
			field_value_q <= '0;
			assembled_q   <= '0;
		end else if (adv_s1) begin
			ctl_q         <= ctl_nxt;
			digit_count_q <= digit_count_nxt;
			field_value_q <= field_value_nxt;
			assembled_q   <= assembled_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			address_q <= res_address;
			status_q  <= res_status;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.address = address_q;
	assign result.status  = status_q;

`ifndef ASSERT_OFF
	// A result that is not valid carries a zero address.
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ipv4p_pkg::ST_VALID) |-> address_q == 32'd0)
		else $error("non-valid result with nonzero address");

	// A new result only appears after a last byte left the input register.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && eob_s1))
		else $error("result without a last byte");

	// The parser is back at the start of a line after each result.
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eob_s1) |=> (ctl_q.phase == ipv4p_pkg::PH_SKIP && !ctl_q.decided
			&& digit_count_q == '0))
		else $error("line state not cleared after result");

	// The digit counter never passes its limit.
	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= DC_W'(MAX_DIGITS))
		else $error("digit count beyond limit");
`endif

endmodule

// File: test/testbench.sv
// Testbench of the IPv4 line address parser: directed and random lines checked by a line parser.
`timescale 1ns / 1ps

module testbench;

	localparam int DIGIT_LIMIT = 32;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 770;

	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// One parse outcome of a line.
	typedef struct packed {
		logic [31:0]        address;
		ipv4p_pkg::status_t status;
	} line_result_t;

	// One directed line: text, optional NUL position, and a typed-in result if obvious.
	typedef struct {
		string              txt;
		int                 nul_at;
		bit                 typed;
		logic [31:0]        addr;
		ipv4p_pkg::status_t st;
	} line_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ipv4p_in_if  line_ch ();
	ipv4p_out_if res_ch ();

	ipv4_line_address_parser #(
		.MAX_DIGITS(DIGIT_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.line(line_ch),
		.result(res_ch)
	);

	always #4 clk = ~clk;

	// Line parse state kept by the testbench.
	ipv4p_pkg::phase_t  ln_phase;
	logic [5:0]         ln_digits;
	logic [30:0]        ln_value;
	logic [31:0]        ln_addr;
	ipv4p_pkg::status_t ln_status;
	bit                 ln_decided;

	line_result_t parsed_q [$];
	logic [7:0]   line_buf [$];
	line_result_t want;
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	bit           steady_mode = 1'b0;
	bit           holdoff_pending = 1'b0;

	line_case_t dir_cases [25] = '{
		'{"0.0.0.0 ", -1, 1'b1, 32'h0000_0000, ipv4p_pkg::ST_VALID},
		'{"255.255.255.255\012", -1, 1'b1, 32'hFFFF_FFFF, ipv4p_pkg::ST_VALID},
		'{" \011 ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_IGNORE},
		'{"", 0, 1'b1, 32'h0, ipv4p_pkg::ST_IGNORE},
		'{"  xyz", 2, 1'b1, 32'h0, ipv4p_pkg::ST_IGNORE},
		'{"1.2.3.4", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"1.2.", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"1..2.3 ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{".1.2.3 ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"1.2.3. ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"1.2.x.4 ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"1.2.3.4x", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{{"0000000000", "0000000000", "0000000000", "01.2.3.4 "}, -1, 1'b1,
			32'h0102_0304, ipv4p_pkg::ST_VALID},
		'{{"0000000000", "0000000000", "0000000000", "000.0.0.0 "}, -1, 1'b1,
			32'h0, ipv4p_pkg::ST_INVALID},
		'{"2147483648.0.0.0 ", -1, 1'b0, 32'h0, ipv4p_pkg::ST_VALID},
		'{"99999999999999999999.1.1.1 ", -1, 1'b0, 32'h0, ipv4p_pkg::ST_VALID},
		'{"1.2.3.4", 7, 1'b1, 32'h0102_0304, ipv4p_pkg::ST_VALID},
		'{"10.0.0.1 trailing junk", -1, 1'b1, 32'h0A00_0001, ipv4p_pkg::ST_VALID},
		'{"x", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{" ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_IGNORE},
		'{"\011\012\013\014\015 192.168.1.1\015", -1, 1'b0, 32'h0, ipv4p_pkg::ST_VALID},
		'{"1.2.3.4\377 ", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"300.1.2.3 ", -1, 1'b0, 32'h0, ipv4p_pkg::ST_VALID},
		'{"1.2.3.4 ", 2, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID},
		'{"\200", -1, 1'b1, 32'h0, ipv4p_pkg::ST_INVALID}
	};

	// Return the line state to the start of a line.
	function automatic void clear_line();
		ln_phase = ipv4p_pkg::PH_SKIP;
		ln_digits = '0;
		ln_value = '0;
		ln_addr = '0;
		ln_status = ipv4p_pkg::ST_VALID;
		ln_decided = 1'b0;
	endfunction

	// Fix the outcome of the line; later bytes are ignored.
	function automatic void settle(ipv4p_pkg::status_t s);
		ln_status = s;
		ln_decided = 1'b1;
	endfunction

	// Merge the finished field into its byte lane of the address.
	function automatic void close_field();
		logic [31:0] wide;
		wide = {1'b0, ln_value};
		case (ln_phase)
			ipv4p_pkg::PH_F1: ln_addr |= wide << 24;
			ipv4p_pkg::PH_F2: ln_addr |= wide << 16;
			ipv4p_pkg::PH_F3: ln_addr |= wide << 8;
			ipv4p_pkg::PH_F4: ln_addr |= wide;
			default: ;
		endcase
	endfunction

	// Append a decimal digit, saturating the field value.
	function automatic void add_digit(logic [7:0] c, bit last);
		logic [34:0] v;
		if (ln_digits >= DIGIT_LIMIT) begin
			settle(ipv4p_pkg::ST_INVALID);
			return;
		end
		ln_digits++;
		v = {4'd0, ln_value} * 35'd10 + 35'(c) - 35'(CH_ZERO);
		ln_value = (v > 35'(ipv4p_pkg::FIELD_MAX)) ? ipv4p_pkg::FIELD_MAX : v[30:0];
		if (last)
			settle(ipv4p_pkg::ST_INVALID);
	endfunction

	// Advance the line state by one accepted byte; a last byte yields the line result.
	function automatic void parse_byte(input logic [7:0] c, input bit last,
			output bit emit, output line_result_t res);
		bit ws;
		bit dig;
		ws = (c == ipv4p_pkg::CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
		dig = c inside {[CH_ZERO:CH_NINE]};
		emit = 1'b0;
		res = '0;
		if (!ln_decided) begin
			if (ln_phase == ipv4p_pkg::PH_SKIP) begin
				if (ws) begin
					if (last)
						settle(ipv4p_pkg::ST_IGNORE);
				end else if (c == ipv4p_pkg::CH_NUL) begin
					settle(ipv4p_pkg::ST_IGNORE);
				end else begin
					ln_phase = ipv4p_pkg::PH_F1;
				end
			end
			if (!ln_decided && ln_phase != ipv4p_pkg::PH_SKIP) begin
				case (ln_phase)
					ipv4p_pkg::PH_F1, ipv4p_pkg::PH_F2, ipv4p_pkg::PH_F3: begin
						if (c == ipv4p_pkg::CH_DOT) begin
							if (ln_digits == 0 || last) begin
								settle(ipv4p_pkg::ST_INVALID);
							end else begin
								close_field();
								ln_phase = ipv4p_pkg::phase_t'(ln_phase + 3'd1);
								ln_digits = '0;
								ln_value = '0;
							end
						end else if (dig) begin
							add_digit(c, last);
						end else begin
							settle(ipv4p_pkg::ST_INVALID);
						end
					end
					ipv4p_pkg::PH_F4: begin
						if (c == ipv4p_pkg::CH_NUL || ws) begin
							if (ln_digits == 0) begin
								settle(ipv4p_pkg::ST_INVALID);
							end else begin
								close_field();
								settle(ipv4p_pkg::ST_VALID);
							end
						end else if (dig) begin
							add_digit(c, last);
						end else begin
							settle(ipv4p_pkg::ST_INVALID);
						end
					end
					default: settle(ipv4p_pkg::ST_INVALID);
				endcase
			end
		end
		if (last) begin
			if (!ln_decided)
				settle(ipv4p_pkg::ST_INVALID);
			res.address = (ln_status == ipv4p_pkg::ST_VALID) ? ln_addr : 32'd0;
			res.status = ln_status;
			emit = 1'b1;
			clear_line();
		end
	endfunction

	// Idle cycles before the next item on either side.
	function automatic int draw_wait();
		return steady_mode ? 0 : int'($urandom_range(0, 18));
	endfunction

	// Any of the six whitespace characters.
	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(9, 14);
		return (r == 14) ? ipv4p_pkg::CH_SPACE : 8'(r);
	endfunction

	// Offer the buffered line byte by byte and queue its result.
	task automatic send_line(input bit typed, input line_result_t typed_res);
		int gap;
		bit emit;
		bit last;
		line_result_t got;
		for (int i = 0; i < line_buf.size(); i++) begin
			last = (i == line_buf.size() - 1);
			gap = draw_wait();
			if (gap > 0) begin
				line_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			line_ch.valid <= 1'b1;
			line_ch.text_byte <= line_buf[i];
			line_ch.end_of_buffer <= last;
			do @(posedge clk); while (!line_ch.ready);
			parse_byte(line_buf[i], last, emit, got);
			if (emit)
				parsed_q.push_back(typed ? typed_res : got);
		end
	endtask

	// Stop offering bytes until every queued result has come out.
	task automatic pause_sender();
		line_ch.valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
	endtask

	// Build a random line: mostly well-formed addresses, some broken, some noise.
	task automatic compose_random_line();
		int kind;
		int n;
		int r;
		int idx;
		kind = $urandom_range(0, 99);
		line_buf.delete();
		if (kind < 8) begin
			n = $urandom_range(1, 8);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 14) begin
			n = $urandom_range(1, 4);
			repeat (n) line_buf.push_back(pick_space());
			if ($urandom_range(0, 2) == 0) begin
				line_buf.push_back(ipv4p_pkg::CH_NUL);
				repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(0, 3)) line_buf.push_back(pick_space());
			for (int f = 1; f <= 4; f++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					n = 0;
				else if (r < 75)
					n = $urandom_range(1, 3);
				else if (r < 93)
					n = $urandom_range(4, 12);
				else
					n = $urandom_range(29, 34);
				repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if (f < 4)
					line_buf.push_back(ipv4p_pkg::CH_DOT);
			end
			r = $urandom_range(0, 9);
			if (r == 1)
				line_buf.push_back(ipv4p_pkg::CH_NUL);
			else if (r > 1)
				line_buf.push_back(pick_space());
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
			// Break some of the well-formed lines.
			if (kind >= 78) begin
				idx = $urandom_range(0, line_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: line_buf[idx] = 8'($urandom_range(0, 255));
					1: if (line_buf.size() > 1) line_buf.delete(idx);
					default: begin
						n = $urandom_range(1, line_buf.size());
						while (line_buf.size() > n)
							void'(line_buf.pop_back());
					end
				endcase
			end
		end
	endtask

	// Result receiver with random stalls and one long hold-off.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (holdoff_pending) begin
				holdoff_pending = 1'b0;
				stall = HOLDOFF_CYCLES;
			end else begin
				stall = draw_wait();
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Compare each accepted result with the oldest queued one.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (parsed_q.size() == 0) begin
				$display("%0t: unexpected result address %h status %0d",
					$time, res_ch.address, res_ch.status);
				mismatch_count++;
			end else begin
				want = parsed_q.pop_front();
				if (res_ch.address !== want.address) begin
					$display("%0t: address expected %h actual %h",
						$time, want.address, res_ch.address);
					mismatch_count++;
				end
				if (res_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, res_ch.status);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (line_ch.valid && line_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed lines, then random lines, then drain and report.
	initial begin
		int sent;
		int nlines;
		line_result_t typed_res;
		line_ch.valid = 1'b0;
		line_ch.text_byte = 8'h00;
		line_ch.end_of_buffer = 1'b0;
		clear_line();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines.
		foreach (dir_cases[k]) begin
			line_buf.delete();
			for (int i = 0; i < dir_cases[k].txt.len(); i++) begin
				if (i == dir_cases[k].nul_at)
					line_buf.push_back(ipv4p_pkg::CH_NUL);
				line_buf.push_back(dir_cases[k].txt[i]);
			end
			if (dir_cases[k].nul_at == dir_cases[k].txt.len())
				line_buf.push_back(ipv4p_pkg::CH_NUL);
			typed_res.address = dir_cases[k].addr;
			typed_res.status = dir_cases[k].st;
			send_line(dir_cases[k].typed, typed_res);
		end
		pause_sender();

		// Random lines, with stretches of no idling and one long receiver hold-off.
		sent = 0;
		nlines = 0;
		typed_res = '0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0)
				steady_mode = !steady_mode;
			if (nlines == 10)
				holdoff_pending = 1'b1;
			if (nlines == 20)
				pause_sender();
			compose_random_line();
			sent += line_buf.size();
			send_line(1'b0, typed_res);
			nlines++;
		end
		pause_sender();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
